// File: hdl/scd_pkg.sv
`default_nettype none
package scd_pkg;

  localparam int unsigned MAX_RES = 64;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_FILL = 2'd1,
    KIND_WB   = 2'd2
  } kind_t;

  typedef enum logic {
    REG_DEV_SECTORS = 1'b0,
    REG_PREFETCH_EN = 1'b1
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOOK, S_SWEEP, S_SWCHK, S_WBRD, S_WB, S_ALLOC, S_PFCHK, S_MRD,
    S_FILL, S_PFILL, S_DONE, S_FIN, S_FL_CHK, S_FL_RD, S_FL_EM, S_FL_END
  } state_t;

  // Per-slot state kept in the slot-state memory.
  typedef struct packed {
    logic       dirty;
    logic       loaded;
    logic [1:0] uses;
  } meta_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] out_sector;
    logic [5:0]  slot;
    logic        hit;
  } res_t;

  // Requests from the sequencer to the output stage.
  typedef struct packed {
    logic emit;
    logic fin;
    res_t res;
  } oq_ctl_t;

endpackage
`default_nettype wire

// File: hdl/scd_ram.sv
`default_nettype none
module scd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: hdl/scd_outq.sv
`default_nettype none
module scd_outq import scd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire oq_ctl_t ctl,
  output logic         go,
  output logic         pend_v,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic [39:0]  m_tdata,  // out_sector, slot
  output logic [2:0]   m_tuser,  // kind, hit
  output logic         m_tlast
);

  res_t pend;
  res_t outr;
  logic out_free;
  logic load;

  // A result waits in the holding register until the next one shows
  // whether it was the last of its transaction.
  assign out_free = !m_tvalid || m_tready;
  assign go = ctl.fin ? out_free : (!pend_v || out_free);
  assign load = (ctl.fin && out_free) || (ctl.emit && go && pend_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (load) begin
        outr     <= pend;
        m_tvalid <= 1'b1;
        m_tlast  <= ctl.fin;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctl.fin && out_free) begin
        pend_v <= 1'b0;
      end else if (ctl.emit && go) begin
        pend   <= ctl.res;
        pend_v <= 1'b1;
      end
    end
  end

  assign m_tdata = {2'b00, outr.slot, outr.out_sector};
  assign m_tuser = {outr.hit, outr.kind};

endmodule
`default_nettype wire

// File: hdl/sector_cache_clock_directory.sv
// Sector cache directory with clock replacement.
// Requests enter on the s_ channel: s_tdata carries the sector, s_tuser
// the operation (read, write, flush, none), the inode flag and the partial
// flag. Each request but none answers with one or more results on the m_
// channel: write backs of evicted slots, fills, and a final completion,
// with m_tlast set on the last result of the request. A flush answers one
// write back per dirty slot, or a single completion when nothing is dirty.
// Only one request is in progress at a time; s_tready is high when the
// sequencer is idle. A lookup walks the tag memory one slot per cycle and
// is repeated for the next sector with read-ahead; with no free slot, a
// clock sweep examines each slot up to four times. A flush visits every
// slot and reads each valid one. Results pass through a holding register
// and an output register, so a stalled receiver simply holds the sequencer
// until room frees up. Configuration writes on the cfg_ channel are always
// accepted. Reset clears the valid flags, the clock hand, the state and the
// device size and turns read-ahead on; the tag and slot-state memories are
// not cleared, as they are only read for valid slots.
`default_nettype none
module sector_cache_clock_directory import scd_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sector
  input  wire logic [3:0]  s_tuser,   // operation, is_inode, partial
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_sector, slot
  output logic [2:0]       m_tuser,   // kind, hit
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_t state, state_next;
  op_t op;
  logic [31:0] sec, key, dev;
  logic inode, part, pe, phase, hit_r, pv_f, freef, chk_v;
  logic [CW-1:0] idx;
  logic [IW-1:0] chk_idx, free_idx, s_idx, p_idx, victim, hand, hand_inc;
  logic [CNT_W-1:0] cnt;
  logic [SLOTS-1:0] valid;

  logic ram_we;
  logic [IW-1:0] ram_addr;
  logic [31:0] ram_q;
  logic meta_we;
  logic [IW-1:0] meta_addr;
  meta_t meta_wd, meta_q;
  oq_ctl_t ctl;
  logic go, pend_v;
  logic found_now, look_end, issue, skip, need_fill, pf_ok, fl_end;
  logic fill_dirty;
  logic [1:0] fill_use;
  logic [IW-1:0] idx_lo;

  assign idx_lo    = idx[IW-1:0];
  assign hand_inc  = (hand == IW'(SLOTS - 1)) ? '0 : hand + IW'(1);
  assign found_now = chk_v && valid[chk_idx] && (ram_q == key);
  assign look_end  = (idx == CW'(SLOTS)) && !chk_v;
  assign issue     = (state == S_LOOK) && (idx != CW'(SLOTS)) && !found_now;
  assign skip      = (phase && hand == s_idx) || !valid[hand];
  assign need_fill = !meta_q.loaded && (op == OP_READ || part);
  assign pf_ok     = pe && (({1'b0, sec} + 33'd1) < {1'b0, dev});
  assign fl_end    = (idx == CW'(SLOTS)) || (cnt == CNT_W'(MAX_RES));
  assign cfg_ready = 1'b1;

  // A write that makes a clean slot dirty gives it one extra clock pass.
  assign fill_dirty = meta_q.dirty || (op == OP_WRITE);
  assign fill_use   = (op == OP_WRITE && !meta_q.dirty) ? (inode ? 2'd3 : 2'd2)
                                                         : (inode ? 2'd2 : 2'd1);

  scd_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tags (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(key), .rdata(ram_q)
  );

  scd_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta (
    .clk(clk), .we(meta_we), .addr(meta_addr), .wdata(meta_wd), .rdata(meta_q)
  );

  scd_outq u_outq (
    .clk(clk), .rst(rst), .ctl(ctl), .go(go), .pend_v(pend_v),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          priority case (op_t'(s_tuser[1:0]))
            OP_NONE:  state_next = S_IDLE;
            OP_FLUSH: state_next = S_FL_CHK;
            default:  state_next = S_LOOK;
          endcase
        end
      end
      S_LOOK: begin
        if (found_now) begin
          state_next = phase ? S_MRD : S_PFCHK;
        end else if (look_end) begin
          state_next = freef ? S_ALLOC : S_SWEEP;
        end
      end
      S_SWEEP: if (!skip) state_next = S_SWCHK;
      S_SWCHK: begin
        if (meta_q.uses == 2'd0) begin
          state_next = meta_q.dirty ? S_WBRD : S_ALLOC;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_WBRD:  state_next = S_WB;
      S_WB:    if (go) state_next = S_ALLOC;
      S_ALLOC: state_next = phase ? S_MRD : S_PFCHK;
      S_PFCHK: state_next = pf_ok ? S_LOOK : S_MRD;
      S_MRD:   state_next = S_FILL;
      S_FILL:  if (!need_fill || go) state_next = S_PFILL;
      S_PFILL: if (!pv_f || go) state_next = S_DONE;
      S_DONE:  if (go) state_next = S_FIN;
      S_FIN:   if (go) state_next = S_IDLE;
      S_FL_CHK: begin
        if (fl_end) begin
          state_next = S_FL_END;
        end else if (valid[idx_lo]) begin
          state_next = S_FL_RD;
        end
      end
      S_FL_RD: state_next = S_FL_EM;
      S_FL_EM: if (!meta_q.dirty || go) state_next = S_FL_CHK;
      S_FL_END: begin
        if (cnt != '0 || go) state_next = S_FIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    ram_we    = 1'b0;
    ram_addr  = '0;
    meta_we   = 1'b0;
    meta_addr = '0;
    meta_wd   = '0;
    ctl       = '0;
    unique case (state)
      S_LOOK:  ram_addr = idx_lo;
      S_SWEEP: meta_addr = hand;
      S_SWCHK: begin
        meta_addr = hand;
        meta_we   = (meta_q.uses != 2'd0);
        meta_wd   = '{meta_q.dirty, meta_q.loaded, meta_q.uses - 2'd1};
      end
      S_WBRD: ram_addr = victim;
      S_WB: begin
        ram_addr = victim;
        ctl.emit = 1'b1;
        ctl.res  = '{KIND_WB, ram_q, 6'(victim), 1'b0};
      end
      S_ALLOC: begin
        ram_addr  = victim;
        ram_we    = 1'b1;
        meta_addr = victim;
        meta_we   = 1'b1;
      end
      S_MRD: meta_addr = s_idx;
      S_FILL: begin
        meta_addr = s_idx;
        meta_we   = !need_fill || go;
        meta_wd   = '{fill_dirty, 1'b1, fill_use};
        ctl.emit  = need_fill;
        ctl.res   = '{KIND_FILL, sec, 6'(s_idx), 1'b0};
      end
      S_PFILL: begin
        meta_addr = p_idx;
        meta_we   = pv_f && go;
        meta_wd   = '{1'b0, 1'b1, 2'd0};
        ctl.emit  = pv_f;
        ctl.res   = '{KIND_FILL, key, 6'(p_idx), 1'b0};
      end
      S_DONE: begin
        ctl.emit = 1'b1;
        ctl.res  = '{KIND_DONE, sec, 6'(s_idx), hit_r};
      end
      S_FIN: ctl.fin = 1'b1;
      S_FL_RD: begin
        ram_addr  = idx_lo;
        meta_addr = idx_lo;
      end
      S_FL_EM: begin
        ram_addr  = idx_lo;
        meta_addr = idx_lo;
        meta_we   = meta_q.dirty && go;
        meta_wd   = '{1'b0, meta_q.loaded, meta_q.uses};
        ctl.emit  = meta_q.dirty;
        ctl.res   = '{KIND_WB, ram_q, 6'(idx_lo), 1'b0};
      end
      S_FL_END: begin
        ctl.emit = (cnt == '0);
        ctl.res  = '{KIND_DONE, 32'd0, 6'd0, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      hand  <= '0;
      dev   <= 32'd0;
      pe    <= 1'b1;
      chk_v <= 1'b0;
    end else begin
      state   <= state_next;
      chk_v   <= issue;
      chk_idx <= idx_lo;
      if (cfg_valid) begin
        if (cfg_index == {1'b0, REG_DEV_SECTORS}) dev <= cfg_data;
        if (cfg_index == {1'b0, REG_PREFETCH_EN}) pe <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          op    <= op_t'(s_tuser[1:0]);
          sec   <= s_tdata;
          key   <= s_tdata;
          inode <= s_tuser[2];
          part  <= s_tuser[3];
          phase <= 1'b0;
          idx   <= '0;
          freef <= 1'b0;
          pv_f  <= 1'b0;
          hit_r <= 1'b0;
          cnt   <= '0;
        end
        S_LOOK: begin
          if (issue) idx <= idx + CW'(1);
          if (chk_v && !valid[chk_idx] && !freef) begin
            freef    <= 1'b1;
            free_idx <= chk_idx;
          end
          if (found_now) begin
            if (!phase) begin
              s_idx <= chk_idx;
              hit_r <= 1'b1;
            end
          end else if (look_end) begin
            victim <= free_idx;
          end
        end
        S_SWEEP: begin
          if (skip) hand <= hand_inc;
        end
        S_SWCHK: begin
          hand <= hand_inc;
          if (meta_q.uses == 2'd0) victim <= hand;
        end
        S_ALLOC: begin
          valid[victim] <= 1'b1;
          if (phase) begin
            p_idx <= victim;
            pv_f  <= 1'b1;
          end else begin
            s_idx <= victim;
          end
        end
        S_PFCHK: begin
          if (pf_ok) begin
            key   <= sec + 32'd1;
            phase <= 1'b1;
            idx   <= '0;
            freef <= 1'b0;
          end
        end
        S_FL_CHK: begin
          if (!fl_end && !valid[idx_lo]) idx <= idx + CW'(1);
        end
        S_FL_EM: begin
          if (!meta_q.dirty || go) begin
            idx <= idx + CW'(1);
            if (meta_q.dirty) cnt <= cnt + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_pin_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC && phase) |-> (victim != s_idx))
    else $error("prefetch allocation took the pinned slot");

  a_fin_has_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> pend_v)
    else $error("final result requested with nothing held");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> valid[s_idx])
    else $error("request slot not valid at fill");

  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !freef)
    else $error("clock sweep started while a free slot exists");

endmodule
`default_nettype wire
